// ===== src/pdra_pkg.sv =====
// ----------------------------------------------------------------------------
// pdra_pkg
// Shared types and constants for the packet descriptor ring allocator.
// ----------------------------------------------------------------------------
package pdra_pkg;

  // Largest byte ring the allocator can manage.
  localparam int unsigned RING_BYTES = 65536;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_PEEK = 2'd1;
  localparam logic [1:0] FUNC_POP  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_PACKET_LIMIT = 2'd0;
  localparam logic [1:0] REG_BYTE_LIMIT   = 2'd1;
  localparam logic [1:0] REG_MAX_LEN      = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OVERSIZE   = 3'd1,
    ST_SLOTS_FULL = 3'd2,
    ST_BYTES_FULL = 3'd3,
    ST_EMPTY      = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] meta_tag;
    logic [16:0] packet_length;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] out_offset;
    logic [16:0] out_length;
    logic [31:0] out_meta;
    logic [7:0]  queue_depth;
    logic [16:0] bytes_used;
  } result_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [16:0] value;
  } cfg_beat_t;

  // Current register settings as seen by the allocator.
  typedef struct packed {
    logic [7:0]  packet_limit;
    logic [16:0] byte_limit;
    logic [16:0] max_len;
  } cfg_regs_t;

  // One packet descriptor.
  typedef struct packed {
    logic [31:0] meta;
    logic [15:0] offset;
    logic [16:0] length;
    logic [16:0] reserved;
  } desc_t;

  // Descriptor write request from the allocator to the descriptor store.
  typedef struct packed {
    logic        we;
    logic [7:0]  addr;
    desc_t       desc;
  } desc_wr_t;

endpackage

// ===== src/pdra_chan_if.sv =====
// ----------------------------------------------------------------------------
// pdra_chan_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface pdra_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/pdra_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pdra_cfg_regs
// Configuration register file, written through its own channel.
// ----------------------------------------------------------------------------
module pdra_cfg_regs
  import pdra_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  pdra_chan_if.sink     cfg,
  output cfg_regs_t     regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.packet_limit <= 8'd255;
      regs.byte_limit   <= 17'd65536;
      regs.max_len      <= 17'd65536;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_PACKET_LIMIT: regs.packet_limit <= cfg.data.value[7:0];
        REG_BYTE_LIMIT:   regs.byte_limit   <= cfg.data.value;
        REG_MAX_LEN:      regs.max_len      <= cfg.data.value;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/pdra_desc_ram.sv =====
// ----------------------------------------------------------------------------
// pdra_desc_ram
// Descriptor store: one write port, one registered read port. A write to the
// address being read in the same cycle is forwarded to the read register.
// ----------------------------------------------------------------------------
module pdra_desc_ram
  import pdra_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned MW    = 32
) (
  input  logic          clk,
  input  desc_wr_t      wr,
  input  logic [AW-1:0] rd_addr,
  output desc_t         rd_desc
);

  logic [MW-1:0] meta_mem     [DEPTH];
  logic [15:0]   offset_mem   [DEPTH];
  logic [16:0]   length_mem   [DEPTH];
  logic [16:0]   reserved_mem [DEPTH];

  logic [MW-1:0] meta_q;
  logic [15:0]   offset_q;
  logic [16:0]   length_q;
  logic [16:0]   reserved_q;
  logic [AW-1:0] wr_addr;
  logic          fwd;

  assign wr_addr = wr.addr[AW-1:0];
  assign fwd     = wr.we && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr.we) begin
      meta_mem[wr_addr]     <= wr.desc.meta[MW-1:0];
      offset_mem[wr_addr]   <= wr.desc.offset;
      length_mem[wr_addr]   <= wr.desc.length;
      reserved_mem[wr_addr] <= wr.desc.reserved;
    end
  end

  always_ff @(posedge clk) begin
    if (fwd) begin
      meta_q     <= wr.desc.meta[MW-1:0];
      offset_q   <= wr.desc.offset;
      length_q   <= wr.desc.length;
      reserved_q <= wr.desc.reserved;
    end else begin
      meta_q     <= meta_mem[rd_addr];
      offset_q   <= offset_mem[rd_addr];
      length_q   <= length_mem[rd_addr];
      reserved_q <= reserved_mem[rd_addr];
    end
  end

  always_comb begin
    rd_desc.meta     = 32'(meta_q);
    rd_desc.offset   = offset_q;
    rd_desc.length   = length_q;
    rd_desc.reserved = reserved_q;
  end

endmodule

// ===== src/pdra_alloc.sv =====
// ----------------------------------------------------------------------------
// pdra_alloc
// Ring pointers and byte accounting. Decides one operation per cycle while go is
// high, from the staged item, updates the pointers and forms the result.
// ----------------------------------------------------------------------------
module pdra_alloc
  import pdra_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned MW    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  item_t         item,
  input  cfg_regs_t     regs,
  input  desc_t         head_desc,
  output desc_wr_t      wr,
  output logic [AW-1:0] rd_addr,
  output result_t       res
);

  localparam logic [16:0] CAP_MAX =
    17'((RING_BYTES < 65536) ? RING_BYTES : 65536);
  localparam logic [8:0] DEPTH9 = 9'(DEPTH);
  localparam logic [31:0] META_MASK =
    (MW >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << MW) - 64'd1);

  logic [7:0]  head_slot, tail_slot;
  logic [15:0] fill_offset;
  logic [16:0] reserved_total;

  logic [7:0]  head_next, tail_next;
  logic [15:0] fill_next;
  logic [16:0] reserved_next;

  logic [8:0]  slot_cnt, limit_p1;
  logic [16:0] cap;
  logic [8:0]  tail_inc, head_inc;
  logic [7:0]  tail_adv, head_adv;
  logic        empty;
  logic [16:0] fo, tailroom, padding, freeb;
  logic [17:0] required;
  logic [15:0] alloc_off;
  logic [17:0] end_off;
  logic [8:0]  depth9;

  always_comb begin
    limit_p1 = {1'b0, regs.packet_limit} + 9'd1;
    slot_cnt = (limit_p1 > DEPTH9) ? DEPTH9 : limit_p1;

    if (regs.byte_limit == 17'd0) begin
      cap = 17'd1;
    end else if (regs.byte_limit > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = regs.byte_limit;
    end

    tail_inc = {1'b0, tail_slot} + 9'd1;
    tail_adv = (tail_inc >= slot_cnt) ? 8'd0 : tail_inc[7:0];
    head_inc = {1'b0, head_slot} + 9'd1;
    head_adv = (head_inc >= slot_cnt) ? 8'd0 : head_inc[7:0];
    empty    = (head_slot == tail_slot);

    // Push placement: restart at zero when the ring is drained or the offset
    // lies beyond a shrunken ring, and skip the tail when the packet won't fit.
    fo        = (reserved_total == 17'd0 || {1'b0, fill_offset} >= cap) ?
                17'd0 : {1'b0, fill_offset};
    tailroom  = cap - fo;
    padding   = (item.packet_length > tailroom) ? tailroom : 17'd0;
    required  = {1'b0, padding} + {1'b0, item.packet_length};
    freeb     = (reserved_total >= cap) ? 17'd0 : cap - reserved_total;
    alloc_off = (padding != 17'd0) ? 16'd0 : fo[15:0];
    end_off   = {2'b00, alloc_off} + {1'b0, item.packet_length};
  end

  always_comb begin
    head_next     = head_slot;
    tail_next     = tail_slot;
    fill_next     = fill_offset;
    reserved_next = reserved_total;

    wr.we            = 1'b0;
    wr.addr          = tail_slot;
    wr.desc.meta     = item.meta_tag & META_MASK;
    wr.desc.offset   = alloc_off;
    wr.desc.length   = item.packet_length;
    wr.desc.reserved = required[16:0];

    res.status      = ST_OK;
    res.out_offset  = 16'd0;
    res.out_length  = 17'd0;
    res.out_meta    = 32'd0;

    if (go) begin
      case (item.func)
        FUNC_PUSH: begin
          if (item.packet_length > regs.max_len || item.packet_length > cap) begin
            res.status = ST_OVERSIZE;
          end else if (tail_adv == head_slot) begin
            res.status = ST_SLOTS_FULL;
          end else if (required > {1'b0, freeb}) begin
            res.status = ST_BYTES_FULL;
            fill_next  = fo[15:0];
          end else begin
            wr.we          = 1'b1;
            res.out_offset = alloc_off;
            fill_next      = (end_off >= {1'b0, cap}) ? 16'd0 : end_off[15:0];
            reserved_next  = reserved_total + required[16:0];
            tail_next      = tail_adv;
          end
        end
        FUNC_PEEK: begin
          if (empty) begin
            res.status = ST_EMPTY;
          end else begin
            res.out_offset = head_desc.offset;
            res.out_length = head_desc.length;
            res.out_meta   = head_desc.meta;
          end
        end
        FUNC_POP: begin
          if (empty) begin
            res.status = ST_EMPTY;
          end else begin
            head_next     = head_adv;
            reserved_next = (head_desc.reserved > reserved_total) ?
                            17'd0 : reserved_total - head_desc.reserved;
          end
        end
        default: begin
        end
      endcase
    end

    if (tail_next >= head_next) begin
      depth9 = {1'b0, tail_next} - {1'b0, head_next};
    end else begin
      depth9 = slot_cnt - {1'b0, head_next} + {1'b0, tail_next};
    end
    res.queue_depth = depth9[7:0];
    res.bytes_used  = reserved_next;

    // The descriptor store reads the entry that will be the head next cycle.
    rd_addr = head_next[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot      <= 8'd0;
      tail_slot      <= 8'd0;
      fill_offset    <= 16'd0;
      reserved_total <= 17'd0;
    end else begin
      head_slot      <= head_next;
      tail_slot      <= tail_next;
      fill_offset    <= fill_next;
      reserved_total <= reserved_next;
    end
  end

endmodule

// ===== src/packet_descriptor_ring_allocator.sv =====
// ----------------------------------------------------------------------------
// packet_descriptor_ring_allocator
// Descriptor queue with a contiguous circular byte ring.
// ----------------------------------------------------------------------------
// Usage: operations arrive on the cmd channel (push, peek head, pop head) and
// each produces exactly one beat on the rsp channel, carrying a status, the
// allocated or head offset, the head length and metadata on a peek, and the
// queue depth and reserved byte count after the operation. The cfg channel
// writes packet_limit, byte_limit and max_len by index; it is always ready
// and should only be used while no operation is in flight.
//
// A cmd beat is captured in an input register. Once the result register is
// free or draining, the pointer logic decides the operation in one pass and
// loads the result register, which presents the rsp beat. One operation is
// accepted per cycle while rsp is not stalled. The descriptor store has a
// registered read that always holds the current head entry, with forwarding
// when a push writes the slot that becomes the head.
//
// Reset (synchronous, active high) empties the queue, zeroes the byte
// accounting and restores the register defaults; the descriptor store itself
// is not cleared. When the receiver stalls rsp, the result register holds its
// beat, the input register fills, and cmd.ready drops until rsp drains.
// ----------------------------------------------------------------------------
module packet_descriptor_ring_allocator
  import pdra_pkg::*;
#(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned META_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  pdra_chan_if.sink   cmd,
  pdra_chan_if.source rsp,
  pdra_chan_if.sink   cfg
);

  // Slot pointers are eight bits wide, so at most 256 slots are ever used.
  localparam int unsigned DEPTH = (SLOTS < 256) ? SLOTS : 256;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned MW    = (META_WIDTH < 32) ? META_WIDTH : 32;

  cfg_regs_t     regs;
  desc_t         head_desc;
  desc_wr_t      wr;
  logic [AW-1:0] rd_addr;
  result_t       res;

  logic    item_vld;
  item_t   item_q;
  logic    rsp_vld;
  result_t rsp_q;
  logic    go;

  // The staged item moves on whenever the result register is free or drains.
  assign go        = item_vld && (!rsp_vld || rsp.ready);
  assign cmd.ready = !item_vld || go;
  assign rsp.valid = rsp_vld;
  assign rsp.data  = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (cmd.ready) begin
      item_vld <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      item_q <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (go) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp_q <= res;
    end
  end

  pdra_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  pdra_alloc #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .MW    (MW)
  ) u_alloc (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .item      (item_q),
    .regs      (regs),
    .head_desc (head_desc),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .res       (res)
  );

  pdra_desc_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .MW    (MW)
  ) u_desc_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_desc (head_desc)
  );

endmodule

// ===== src/pdra_checker.sv =====
// ----------------------------------------------------------------------------
// pdra_checker
// Port-level checks on the allocator's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pdra_checker
  import pdra_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input result_t rsp_data
);

  // A stalled result beat stays presented.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped while stalled");

  // Reset leaves no result pending.
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending right after reset");

  // A refused or empty operation reports no offset, length or metadata.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_OK |->
      rsp_data.out_offset == 16'd0 && rsp_data.out_length == 17'd0 &&
      rsp_data.out_meta == 32'd0)
    else $error("failed operation carries descriptor data");

  // An empty answer means the queue really is empty. Bytes may still be held
  // when the slot ring was shrunk under queued packets.
  a_empty_depth: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_EMPTY |->
      rsp_data.queue_depth == 8'd0)
    else $error("empty status with packets queued");

  // Reserved bytes never exceed the largest ring.
  a_bytes_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.bytes_used <= 17'd65536)
    else $error("reserved bytes beyond ring size");

endmodule

bind packet_descriptor_ring_allocator pdra_checker u_pdra_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packet descriptor ring allocator. Operations
// are driven on the cmd channel with random gaps, responses are taken with
// random back-pressure, and every response is compared against a
// cycle-free behavioral copy of the allocator kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
  import pdra_pkg::*;

  // The func encoding that the allocator treats as a no-op.
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // Cycles without any beat on any channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;

  // Length of the single long response hold-off that backs up the pipeline.
  localparam int unsigned HOLD_CYCLES = 64;

  // Response count at which that hold-off starts.
  localparam int unsigned HOLD_AT = 60;

  // Cycles to wait after the last response before touching the registers or
  // ending the run.
  localparam int unsigned SETTLE_CYCLES = 4;

  logic clk;
  logic rst;

  pdra_chan_if #(.T(item_t))     cmd_if ();
  pdra_chan_if #(.T(result_t))   rsp_if ();
  pdra_chan_if #(.T(cfg_beat_t)) cfg_if ();

  packet_descriptor_ring_allocator u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // --------------------------------------------------------------------------
  // Bench bookkeeping.
  // --------------------------------------------------------------------------
  item_t       op_backlog[$];      // Operations not yet offered on cmd.
  result_t     owed_results[$];    // Responses the allocator still owes, oldest first.
  int unsigned ops_queued   = 0;   // Operations placed in the backlog so far.
  int unsigned ops_taken    = 0;   // Operations accepted by the allocator.
  int unsigned results_seen = 0;   // Responses accepted from the allocator.
  int unsigned bad_results  = 0;   // Wrong or unexpected responses.
  int unsigned quiet_cycles = 0;   // Consecutive cycles with no beat anywhere.
  int unsigned hold_left    = 0;   // Remaining cycles of the long hold-off.
  bit          hold_done    = 1'b0;
  bit          cmd_took     = 1'b0;  // The cmd beat on offer was taken at the last edge.

  // --------------------------------------------------------------------------
  // Behavioral copy of the allocator: register settings, ring pointers, byte
  // accounting and the descriptor store.
  // --------------------------------------------------------------------------
  logic [7:0]  lim_packets;
  logic [16:0] lim_bytes;
  logic [16:0] lim_len;
  int unsigned head_ix;
  int unsigned tail_ix;
  int unsigned fill_at;
  int unsigned held_bytes;
  desc_t       slot_desc [256];

  // The slot ring wraps at packet_limit + 1 entries.
  function automatic int unsigned slot_total();
    return int'(lim_packets) + 1;
  endfunction

  // A zero byte limit behaves as one byte; anything past the ring is capped.
  function automatic int unsigned ring_cap();
    if (lim_bytes == 0) return 1;
    if (lim_bytes > RING_BYTES) return RING_BYTES;
    return lim_bytes;
  endfunction

  // A pointer left beyond a shrunken slot ring wraps to 0 on its next step.
  function automatic int unsigned next_slot(int unsigned s);
    int unsigned n;
    n = s + 1;
    return (n >= slot_total()) ? 0 : n;
  endfunction

  function automatic void apply_reg(cfg_beat_t w);
    case (w.index)
      REG_PACKET_LIMIT: lim_packets = w.value[7:0];
      REG_BYTE_LIMIT:   lim_bytes   = w.value;
      REG_MAX_LEN:      lim_len     = w.value;
      default: ;
    endcase
  endfunction

  // Applies one operation to the behavioral state and returns the response
  // the allocator must give for it.
  function automatic result_t ring_op_result(item_t op);
    result_t     r;
    int unsigned cap;
    int unsigned nxt;
    int unsigned room;
    int unsigned pad;
    int unsigned need;
    int unsigned avail;
    int unsigned rsv;
    int unsigned depth;
    r = '0;
    r.status = ST_OK;
    case (op.func)
      FUNC_PUSH: begin
        cap = ring_cap();
        if (op.packet_length > lim_len || op.packet_length > cap) begin
          r.status = ST_OVERSIZE;
        end else begin
          nxt = next_slot(tail_ix);
          if (nxt == head_ix) begin
            r.status = ST_SLOTS_FULL;
          end else begin
            // An empty ring, or a fill point past a shrunken ring, restarts
            // at offset 0. This happens even when the push is then refused.
            if (held_bytes == 0 || fill_at >= cap) fill_at = 0;
            room  = cap - fill_at;
            pad   = (op.packet_length > room) ? room : 0;
            need  = pad + op.packet_length;
            avail = (held_bytes >= cap) ? 0 : cap - held_bytes;
            if (need > avail) begin
              r.status = ST_BYTES_FULL;
            end else begin
              // A packet that does not fit in the tail wraps to offset 0 and
              // the skipped tail is charged to it as padding.
              if (pad != 0) fill_at = 0;
              slot_desc[tail_ix] = desc_t'{meta: op.meta_tag, offset: fill_at[15:0],
                                           length: op.packet_length, reserved: need[16:0]};
              r.out_offset = fill_at[15:0];
              fill_at += op.packet_length;
              if (fill_at >= cap) fill_at = 0;
              held_bytes += need;
              tail_ix = nxt;
            end
          end
        end
      end
      FUNC_PEEK: begin
        if (head_ix == tail_ix) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_offset = slot_desc[head_ix].offset;
          r.out_length = slot_desc[head_ix].length;
          r.out_meta   = slot_desc[head_ix].meta;
        end
      end
      FUNC_POP: begin
        if (head_ix == tail_ix) begin
          r.status = ST_EMPTY;
        end else begin
          // Freeing more than is held leaves the byte count at zero.
          rsv = slot_desc[head_ix].reserved;
          head_ix = next_slot(head_ix);
          held_bytes = (rsv > held_bytes) ? 0 : held_bytes - rsv;
        end
      end
      default: ;
    endcase
    if (tail_ix >= head_ix) depth = tail_ix - head_ix;
    else depth = slot_total() - head_ix + tail_ix;
    r.queue_depth = depth[7:0];
    r.bytes_used  = held_bytes[16:0];
    return r;
  endfunction

  function automatic string show_result(result_t r);
    return $sformatf("status=%0d offset=%0d length=%0d meta=%h depth=%0d used=%0d",
                     r.status, r.out_offset, r.out_length, r.out_meta,
                     r.queue_depth, r.bytes_used);
  endfunction

  // Compares one response beat with the oldest owed response.
  function automatic void check_result(result_t got);
    result_t want;
    bit      bad;
    results_seen++;
    if (owed_results.size() == 0) begin
      if (bad_results < 10)
        $display("response %0d arrived with nothing owed: %s", results_seen,
                 show_result(got));
      bad_results++;
      return;
    end
    want = owed_results.pop_front();
    bad = (got.status      !== want.status)     ||
          (got.out_offset  !== want.out_offset) ||
          (got.out_length  !== want.out_length) ||
          (got.out_meta    !== want.out_meta)   ||
          (got.queue_depth !== want.queue_depth)||
          (got.bytes_used  !== want.bytes_used);
    if (bad) begin
      if (bad_results < 10) begin
        $display("response %0d mismatch", results_seen);
        $display("  expected %s", show_result(want));
        $display("  actual   %s", show_result(got));
      end
      bad_results++;
    end
  endfunction

  // Both sides drop their random gaps inside this window of beats, which
  // gives one long stretch of back-to-back traffic.
  function automatic bit in_calm(int unsigned n);
    return n >= 300 && n < 450;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders. They only fill the backlog; the driver paces it.
  // --------------------------------------------------------------------------
  function automatic void queue_op(logic [1:0] f, logic [31:0] tag, logic [16:0] len);
    item_t op;
    op.func          = f;
    op.meta_tag      = tag;
    op.packet_length = len;
    op_backlog.push_back(op);
    ops_queued++;
  endfunction

  // A random blend of operations. Lengths are mostly at most len_cap, with a
  // few drawn from 0 to RING_BYTES so that oversize refusals show up.
  // Peeks and pops still carry random tag and length bits.
  function automatic void queue_mix(int unsigned n, int unsigned push_pct,
                                    int unsigned pop_pct, int unsigned len_cap,
                                    int unsigned wide_pct);
    int unsigned pick;
    logic [16:0] len;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < wide_pct) len = 17'($urandom_range(RING_BYTES));
      else len = 17'($urandom_range(len_cap));
      if (pick < push_pct) queue_op(FUNC_PUSH, $urandom(), len);
      else if (pick < push_pct + pop_pct) queue_op(FUNC_POP, $urandom(), len);
      else if (pick < 97) queue_op(FUNC_PEEK, $urandom(), len);
      else queue_op(FUNC_NONE, $urandom(), len);
    end
  endfunction

  // With the full 256-slot ring and an empty queue, 255 pushes, one pop and
  // one more push write every descriptor slot once. After this no later
  // sequence, however the limits move, can read a slot that was never filled.
  // Small lengths keep the total under the byte ring.
  function automatic void queue_slot_sweep();
    for (int i = 0; i < 255; i++) begin
      queue_op(FUNC_PUSH, $urandom(), 17'($urandom_range(255)));
      if ($urandom_range(7) == 0)
        queue_op(FUNC_PEEK, $urandom(), 17'($urandom_range(RING_BYTES)));
    end
    queue_op(FUNC_POP, $urandom(), 17'($urandom_range(RING_BYTES)));
    queue_op(FUNC_PUSH, $urandom(), 17'($urandom_range(255)));
  endfunction

  // --------------------------------------------------------------------------
  // Clock.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver. Inputs move on the falling edge. A beat on offer stays put until
  // it is taken; after that the next backlog entry may follow at once or
  // after a random gap.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_took) begin
      if (op_backlog.size() != 0 && (in_calm(ops_taken) || $urandom_range(99) >= 34)) begin
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= op_backlog.pop_front();
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response side. Ready is random, except for one long hold-off early on:
  // the result register fills, then the input register, and cmd.ready must
  // drop while the driver keeps offering beats.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      rsp_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      rsp_if.ready <= in_calm(results_seen) || ($urandom_range(99) >= 34);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled on the rising edge. Responses are checked
  // before the operation taken at the same edge is predicted; its own
  // response cannot appear before the next edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_took <= 1'b0;
    end else begin
      cmd_took <= cmd_if.valid && cmd_if.ready;
      if (cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.data);
      if (rsp_if.valid && rsp_if.ready) check_result(rsp_if.data);
      if (cmd_if.valid && cmd_if.ready) begin
        owed_results.push_back(ring_op_result(cmd_if.data));
        ops_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog. Any beat on any channel clears the count.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers.
  // --------------------------------------------------------------------------

  // Waits until every queued operation has been answered, plus a little
  // slack, so that the allocator is idle. Returns on a falling edge.
  task automatic settle();
    while (results_seen < ops_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write on the cfg channel. Returns on a rising edge, so that
  // backlog filling and the next write never share a step with the driver.
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_if.data  <= cfg_beat_t'{index: idx, value: val};
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    rsp_if.ready = 1'b0;

    // Register defaults and an empty ring, as after reset.
    lim_packets = 8'd255;
    lim_bytes   = 17'(RING_BYTES);
    lim_len     = 17'(RING_BYTES);
    head_ix     = 0;
    tail_ix     = 0;
    fill_at     = 0;
    held_bytes  = 0;
    foreach (slot_desc[i]) slot_desc[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default limits. Peek and pop on an empty queue, the unused func code,
    // a zero-length packet, a packet that takes the whole ring, a push with
    // no bytes left, then reading back and draining.
    queue_op(FUNC_PEEK, 32'h0, 17'h0);
    queue_op(FUNC_POP,  32'hFFFF_FFFF, 17'h1_0000);
    queue_op(FUNC_NONE, 32'hFFFF_FFFF, 17'h1_0000);
    queue_op(FUNC_PUSH, 32'h0, 17'd0);
    queue_op(FUNC_PUSH, 32'hFFFF_FFFF, 17'h1_0000);
    queue_op(FUNC_PUSH, 32'hA5A5_5A5A, 17'd1);
    queue_op(FUNC_PEEK, 32'h0, 17'h0);
    queue_op(FUNC_POP,  32'h0, 17'h0);
    queue_op(FUNC_PEEK, 32'h0, 17'h0);
    queue_op(FUNC_POP,  32'h0, 17'h0);
    queue_op(FUNC_POP,  32'h0, 17'h0);
    settle();

    // A three-slot ring of 300 bytes with a 120-byte length limit: an
    // oversize refusal, slots running out, a packet padded back to offset 0,
    // and the fill point restarting at 0 once the ring empties.
    write_reg(REG_PACKET_LIMIT, 17'd2);
    write_reg(REG_BYTE_LIMIT, 17'd300);
    write_reg(REG_MAX_LEN, 17'd120);
    queue_op(FUNC_PUSH, $urandom(), 17'd121);
    queue_op(FUNC_PUSH, $urandom(), 17'd120);
    queue_op(FUNC_PUSH, $urandom(), 17'd120);
    queue_op(FUNC_PUSH, $urandom(), 17'd10);
    queue_op(FUNC_POP,  $urandom(), 17'd0);
    queue_op(FUNC_PUSH, $urandom(), 17'd70);
    queue_op(FUNC_PEEK, $urandom(), 17'd0);
    queue_op(FUNC_POP,  $urandom(), 17'd0);
    queue_op(FUNC_POP,  $urandom(), 17'd0);
    queue_op(FUNC_PUSH, $urandom(), 17'd5);
    queue_op(FUNC_POP,  $urandom(), 17'd0);
    settle();

    // Full limits again, then fill every descriptor slot. The long response
    // hold-off lands inside this stretch.
    write_reg(REG_PACKET_LIMIT, 17'd255);
    write_reg(REG_BYTE_LIMIT, 17'(RING_BYTES));
    write_reg(REG_MAX_LEN, 17'(RING_BYTES));
    queue_slot_sweep();
    settle();

    // Shrink both rings under a nearly full queue. The held bytes exceed the
    // new ring, so pops free stale reservations and pushes find no room.
    write_reg(REG_PACKET_LIMIT, 17'd7);
    write_reg(REG_BYTE_LIMIT, 17'd5000);
    write_reg(REG_MAX_LEN, 17'd3000);
    queue_mix(80, 35, 45, 2500, 5);
    settle();

    // Grow them back while whatever is left stays queued.
    write_reg(REG_PACKET_LIMIT, 17'd255);
    write_reg(REG_BYTE_LIMIT, 17'(RING_BYTES));
    write_reg(REG_MAX_LEN, 17'(RING_BYTES));
    queue_mix(80, 50, 35, 4000, 5);
    settle();

    // A small byte ring with packets up to more than half of it, so that
    // padding at the wrap point is common.
    write_reg(REG_PACKET_LIMIT, 17'd15);
    write_reg(REG_BYTE_LIMIT, 17'd1000);
    write_reg(REG_MAX_LEN, 17'd600);
    queue_mix(80, 50, 35, 600, 3);
    settle();

    // A packet limit of zero leaves a single slot.
    write_reg(REG_PACKET_LIMIT, 17'd0);
    queue_op(FUNC_PUSH, $urandom(), 17'd10);
    queue_op(FUNC_PEEK, $urandom(), 17'd0);
    queue_op(FUNC_POP,  $urandom(), 17'd0);
    queue_op(FUNC_PUSH, $urandom(), 17'd0);
    settle();

    // A byte limit of zero acts as a one-byte ring, with two slots.
    write_reg(REG_PACKET_LIMIT, 17'd1);
    write_reg(REG_BYTE_LIMIT, 17'd0);
    write_reg(REG_MAX_LEN, 17'(RING_BYTES));
    queue_op(FUNC_PUSH, $urandom(), 17'd1);
    queue_op(FUNC_PUSH, $urandom(), 17'd2);
    queue_op(FUNC_PUSH, $urandom(), 17'd1);
    queue_op(FUNC_PEEK, $urandom(), 17'd0);
    queue_op(FUNC_POP,  $urandom(), 17'd0);
    queue_op(FUNC_POP,  $urandom(), 17'd0);
    queue_op(FUNC_PEEK, $urandom(), 17'd0);
    settle();

    // One-byte ring, full slot ring.
    write_reg(REG_PACKET_LIMIT, 17'd255);
    write_reg(REG_BYTE_LIMIT, 17'd1);
    queue_mix(30, 50, 40, 2, 0);
    settle();

    // Largest ring, smallest length limit.
    write_reg(REG_PACKET_LIMIT, 17'd200);
    write_reg(REG_BYTE_LIMIT, 17'(RING_BYTES));
    write_reg(REG_MAX_LEN, 17'd1);
    queue_mix(40, 50, 35, 1, 10);
    settle();

    if (bad_results == 0 && owed_results.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
